/* rtl/core/hypervector_context_bundler_top_assert.svh */
// Assertion macros for the context bundler checker
`ifndef HYPERVECTOR_CONTEXT_BUNDLER_TOP_ASSERT_SVH
`define HYPERVECTOR_CONTEXT_BUNDLER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define HVCB_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define HVCB_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/hvcb_pkg.sv */
// Shared types and constants of the context bundler
`default_nettype none
package hvcb_pkg;

  localparam int VOCAB_SIZE_DEF = 256;
  localparam int VECTOR_DIM_DEF = 256;
  localparam int MAX_WINDOW_DEF = 4;

  localparam logic [15:0] DECAY_RST = 16'd65470;
  localparam logic [2:0]  WLEN_RST  = 3'd4;

  localparam logic [1:0] MODE_TOKEN = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic REG_DECAY = 1'b0;
  localparam logic REG_WLEN  = 1'b1;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } emb_t;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
  } base_t;

endpackage
`default_nettype wire

/* rtl/core/hvcb_mac.sv */
// Decay multiply (registered) then round, base add and saturate
`default_nettype none
module hvcb_mac (
  input  wire                 clk,
  input  wire                 en,
  input  hvcb_pkg::emb_t      part,
  input  hvcb_pkg::base_t     base,
  input  wire          [15:0] decay,
  output hvcb_pkg::emb_t      res
);

  logic signed [48:0] prod_re_r;
  logic signed [48:0] prod_im_r;
  hvcb_pkg::base_t    base_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_re_r <= part.re * $signed({1'b0, decay});
      prod_im_r <= part.im * $signed({1'b0, decay});
      base_r    <= base;
    end
  end

  function automatic logic signed [31:0] finish(input logic signed [48:0] prod,
                                                input logic signed [15:0] b);
    logic signed [49:0] rnd;
    logic signed [34:0] sum;
    begin
      rnd = 50'(prod) + 50'sd32768;
      sum = 35'($signed(rnd[49:16])) + (35'(b) <<< 5);
      if (sum > 35'sd2147483647)       finish = 32'sh7fffffff;
      else if (sum < -35'sd2147483648) finish = 32'sh80000000;
      else                             finish = sum[31:0];
    end
  endfunction

  assign res.re = finish(prod_re_r, base_r.re);
  assign res.im = finish(prod_im_r, base_r.im);

endmodule
`default_nettype wire

/* rtl/core/hypervector_context_bundler_top.sv */
// Hyperdimensional context bundler: base/embedding stores and update sequencer
//
// One item at a time. A load or clear-window word goes from idle straight to
// the done state and a read passes a data state first; a token with a word in
// range steps, per element per window entry, through issue, A multiply, A write,
// C multiply and C write, then updates the window (at once if it is empty), an
// order set by the single read port of the embedding memory and the
// multiply/add stages of the update. A finished word waits in the done state
// while the previous result word is held by out_ready low. After reset the
// embedding memory is zeroed one entry per cycle over all of its
// 2**(clog2(VOCAB_SIZE)+clog2(VECTOR_DIM)) entries (65536 at the defaults), with
// in_ready low; configuration writes are taken during that pass.
`default_nettype none
module hypervector_context_bundler_top #(
  parameter int VOCAB_SIZE = hvcb_pkg::VOCAB_SIZE_DEF,
  parameter int VECTOR_DIM = hvcb_pkg::VECTOR_DIM_DEF,
  parameter int MAX_WINDOW = hvcb_pkg::MAX_WINDOW_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire        [1:0]  in_mode,
  input  wire        [7:0]  in_word,
  input  wire        [7:0]  in_element,
  input  wire signed [15:0] in_base_real,
  input  wire signed [15:0] in_base_imag,
  output logic              out_valid,
  input  wire               out_ready,
  output logic              out_read_valid,
  output logic signed [31:0] out_embed_real,
  output logic signed [31:0] out_embed_imag,
  input  wire               cfg_we,
  input  wire               cfg_index,
  input  wire        [15:0] cfg_wdata
);

  localparam int WW = (VOCAB_SIZE > 1) ? $clog2(VOCAB_SIZE) : 1;
  localparam int DW = $clog2(VECTOR_DIM);
  localparam int AW = WW + DW;
  localparam int KW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 2);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RDAT = 4'd2;
  localparam logic [3:0] S_ISSA = 4'd3;
  localparam logic [3:0] S_MULA = 4'd4;
  localparam logic [3:0] S_WRA  = 4'd5;
  localparam logic [3:0] S_MULC = 4'd6;
  localparam logic [3:0] S_WRC  = 4'd7;
  localparam logic [3:0] S_WIN  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [15:0]   decay_r;
  logic [2:0]    wlen_r;
  logic [AW-1:0] clr_r;
  logic [WW-1:0] a_r;
  logic [DW-1:0] d_r;
  logic [KW-1:0] k_r;
  logic [CW-1:0] cnt_r;
  logic [WW-1:0] win_r [MAX_WINDOW];
  logic          rd_hit_r;
  hvcb_pkg::emb_t fwd_r;

  logic          out_valid_r, out_rv_r;
  hvcb_pkg::emb_t out_emb_r;

  // memories
  hvcb_pkg::emb_t  emb_mem  [2**AW];
  hvcb_pkg::base_t base_mem [2**AW];
  hvcb_pkg::emb_t  emb_q;
  hvcb_pkg::base_t base_q;

  logic            emb_we, base_we, emb_re, base_re;
  logic [AW-1:0]   emb_wa, emb_ra, base_ra, base_wa;
  hvcb_pkg::emb_t  emb_wd;

  logic            acc, word_ok, elem_ok, self_hit, d_last, k_last;
  logic [WW-1:0]   c_id;
  logic [AW-1:0]   ia, ic, in_addr;
  hvcb_pkg::emb_t  mac_part, mac_res;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign word_ok  = 32'(in_word) < VOCAB_SIZE;
  assign elem_ok  = 32'(in_element) < VECTOR_DIM;
  assign in_addr  = {WW'(in_word), DW'(in_element)};
  assign c_id     = win_r[k_r];
  assign ia       = {a_r, d_r};
  assign ic       = {c_id, d_r};
  assign self_hit = (c_id == a_r);
  assign d_last   = (d_r == DW'(VECTOR_DIM - 1));
  assign k_last   = (CW'(k_r) + CW'(1) == cnt_r);

  always_comb begin
    emb_we  = 1'b0;
    emb_wa  = ia;
    emb_wd  = mac_res;
    emb_re  = 1'b0;
    emb_ra  = ia;
    base_re = 1'b0;
    base_ra = ic;
    base_we = acc && (in_mode == hvcb_pkg::MODE_LOAD) && word_ok && elem_ok;
    base_wa = in_addr;
    case (state_r)
      S_CLR: begin
        emb_we = 1'b1;
        emb_wa = clr_r;
        emb_wd = '0;
      end
      S_IDLE: begin
        emb_re = acc && (in_mode == hvcb_pkg::MODE_READ);
        emb_ra = in_addr;
      end
      S_ISSA: begin
        emb_re  = 1'b1;
        base_re = 1'b1;
      end
      S_WRA: begin
        emb_we  = 1'b1;
        emb_re  = 1'b1;
        emb_ra  = ic;
        base_re = 1'b1;
        base_ra = ia;
      end
      S_WRC: begin
        emb_we = 1'b1;
        emb_wa = ic;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emb_we) emb_mem[emb_wa] <= emb_wd;
    if (emb_re) emb_q <= emb_mem[emb_ra];
  end

  always_ff @(posedge clk) begin
    if (base_we) base_mem[base_wa] <= {in_base_real, in_base_imag};
    if (base_re) base_q <= base_mem[base_ra];
  end

  // self context: the C read raced the A write, take the written value
  assign mac_part = (state_r == S_MULC && self_hit) ? fwd_r : emb_q;

  hvcb_mac u_mac (
    .clk   (clk),
    .en    (state_r == S_MULA || state_r == S_MULC),
    .part  (mac_part),
    .base  (base_q),
    .decay (decay_r),
    .res   (mac_res)
  );

  // window after a token: append, keep the newest eff-length ids
  logic [CW-1:0] n_app, lim, drop;
  logic [WW-1:0] tmp [MAX_WINDOW + 1];
  logic [WW-1:0] win_nxt [MAX_WINDOW];
  logic [CW-1:0] cnt_win;

  always_comb begin
    n_app = cnt_r + CW'(1);
    if (wlen_r == 3'd0) lim = CW'(1);
    else if (32'(wlen_r) > MAX_WINDOW) lim = CW'(MAX_WINDOW);
    else lim = CW'(wlen_r);
    drop    = (n_app > lim) ? n_app - lim : '0;
    cnt_win = n_app - drop;
    for (int i = 0; i <= MAX_WINDOW; i++) begin
      if (i < MAX_WINDOW && CW'(i) < cnt_r) tmp[i] = win_r[i];
      else tmp[i] = a_r;
    end
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (32'(i) + 32'(drop) <= MAX_WINDOW) win_nxt[i] = tmp[i + 32'(drop)];
      else win_nxt[i] = win_r[i];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (&clr_r) state_nxt = S_IDLE;
      S_IDLE: begin
        if (acc) begin
          if (in_mode == hvcb_pkg::MODE_READ) state_nxt = S_RDAT;
          else if (in_mode == hvcb_pkg::MODE_TOKEN && word_ok)
            state_nxt = (cnt_r == '0) ? S_WIN : S_ISSA;
          else state_nxt = S_DONE;
        end
      end
      S_RDAT: state_nxt = S_DONE;
      S_ISSA: state_nxt = S_MULA;
      S_MULA: state_nxt = S_WRA;
      S_WRA:  state_nxt = S_MULC;
      S_MULC: state_nxt = S_WRC;
      S_WRC:  state_nxt = (d_last && k_last) ? S_WIN : S_ISSA;
      S_WIN:  state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      cnt_r       <= '0;
      decay_r     <= hvcb_pkg::DECAY_RST;
      wlen_r      <= hvcb_pkg::WLEN_RST;
      out_valid_r <= 1'b0;
      d_r         <= '0;
      k_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + AW'(1);
      if (cfg_we) begin
        if (cfg_index == hvcb_pkg::REG_DECAY) decay_r <= cfg_wdata;
        else wlen_r <= cfg_wdata[2:0];
      end
      if (acc && in_mode == hvcb_pkg::MODE_CLEAR) cnt_r <= '0;
      if (acc) begin
        d_r <= '0;
        k_r <= '0;
      end
      if (state_r == S_WRC) begin
        d_r <= d_last ? '0 : d_r + DW'(1);
        if (d_last) k_r <= k_r + KW'(1);
      end
      if (state_r == S_WIN) cnt_r <= cnt_win;
      if (state_r == S_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_r      <= WW'(in_word);
      rd_hit_r <= (in_mode == hvcb_pkg::MODE_READ) && word_ok && elem_ok;
    end
    if (state_r == S_WRA) fwd_r <= mac_res;
    if (state_r == S_WIN) begin
      for (int i = 0; i < MAX_WINDOW; i++) win_r[i] <= win_nxt[i];
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_rv_r  <= rd_hit_r;
      out_emb_r <= rd_hit_r ? emb_q : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_valid = out_rv_r;
  assign out_embed_real = out_emb_r.re;
  assign out_embed_imag = out_emb_r.im;

endmodule
`default_nettype wire

/* rtl/core/hvcb_checker.sv */
// Port-level checker for the context bundler, bound to the top level
`default_nettype none
`include "hypervector_context_bundler_top_assert.svh"
module hvcb_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_valid,
  input wire               in_ready,
  input wire               out_valid,
  input wire               out_ready,
  input wire               out_read_valid,
  input wire signed [31:0] out_embed_real,
  input wire signed [31:0] out_embed_imag
);

  `HVCB_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")
  `HVCB_AST_NXT(a_out_stable, out_valid && !out_ready, $stable(out_embed_real) && $stable(out_embed_imag) && $stable(out_read_valid), "stalled result changed")
  `HVCB_AST_NOW(a_zero_parts, out_valid && !out_read_valid, out_embed_real == 0 && out_embed_imag == 0, "non-read result carries data")
  `HVCB_AST_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second word taken while busy")

endmodule

bind hypervector_context_bundler_top hvcb_checker u_hvcb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_read_valid (out_read_valid),
  .out_embed_real (out_embed_real),
  .out_embed_imag (out_embed_imag)
);
`default_nettype wire

/* tb/hvcb_checker.sv */
// Checker for the context bundler: tracks stores and window, compares each result word
`timescale 1ns / 100ps
module hvcb_scoreboard (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_ready,
  input  wire        [1:0]  in_mode,
  input  wire        [7:0]  in_word,
  input  wire        [7:0]  in_element,
  input  wire signed [15:0] in_base_real,
  input  wire signed [15:0] in_base_imag,
  input  wire               out_valid,
  input  wire               out_ready,
  input  wire               out_read_valid,
  input  wire signed [31:0] out_embed_real,
  input  wire signed [31:0] out_embed_imag,
  input  wire               cfg_we,
  input  wire               cfg_index,
  input  wire        [15:0] cfg_wdata,
  output int                fails,
  output int                pending
);

  typedef struct {
    logic              rv;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } emb_word_t;

  localparam int EXP_DEPTH = 16;

  logic signed [15:0] base_re [0:65535];
  logic signed [15:0] base_im [0:65535];
  int                 emb_re  [0:65535];
  int                 emb_im  [0:65535];
  // oldest id first; one spare slot for the id being appended
  logic [7:0]         ctx_ids [0:hvcb_pkg::MAX_WINDOW_DEF];
  int                 ctx_n   = 0;
  logic [15:0]        decay_q = hvcb_pkg::DECAY_RST;
  logic [2:0]         wlen_q  = hvcb_pkg::WLEN_RST;
  emb_word_t          exp_words [EXP_DEPTH];
  logic [3:0]         exp_head  = '0;
  logic [3:0]         exp_tail  = '0;
  int                 exp_count = 0;
  int                 fail_cnt  = 0;

  assign fails   = fail_cnt;
  assign pending = exp_count;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_cnt++;
  endtask

  // sat32(round(p * decay / 2^16) + b * 32)
  function automatic int decay_mix(input int p, input logic signed [15:0] b);
    longint prod;
    longint sum;
    prod = longint'(p) * longint'({16'd0, decay_q});
    sum  = ((prod + 32768) >>> 16) + longint'(b) * 32;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return int'(sum);
  endfunction

  task automatic bundle_token(input logic [7:0] tok);
    int ia;
    int ic;
    int lim;
    for (int k = 0; k < ctx_n; k++) begin
      for (int d = 0; d < 256; d++) begin
        ia = int'({tok, d[7:0]});
        ic = int'({ctx_ids[k], d[7:0]});
        emb_re[ia] = decay_mix(emb_re[ia], base_re[ic]);
        emb_im[ia] = decay_mix(emb_im[ia], base_im[ic]);
        emb_re[ic] = decay_mix(emb_re[ic], base_re[ia]);
        emb_im[ic] = decay_mix(emb_im[ic], base_im[ia]);
      end
    end
    ctx_ids[ctx_n] = tok;
    ctx_n++;
    lim = (int'(wlen_q) < 1) ? 1 :
          (int'(wlen_q) > hvcb_pkg::MAX_WINDOW_DEF) ? hvcb_pkg::MAX_WINDOW_DEF : int'(wlen_q);
    while (ctx_n > lim) begin
      for (int j = 0; j < hvcb_pkg::MAX_WINDOW_DEF; j++) ctx_ids[j] = ctx_ids[j + 1];
      ctx_n--;
    end
  endtask

  always @(posedge clk) begin
    emb_word_t w;
    emb_word_t want;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == hvcb_pkg::REG_DECAY) decay_q = cfg_wdata;
        else wlen_q = cfg_wdata[2:0];
      end
      if (in_valid && in_ready) begin
        w = '{1'b0, 32'sd0, 32'sd0};
        case (in_mode)
          hvcb_pkg::MODE_TOKEN: bundle_token(in_word);
          hvcb_pkg::MODE_LOAD: begin
            base_re[{in_word, in_element}] = in_base_real;
            base_im[{in_word, in_element}] = in_base_imag;
          end
          hvcb_pkg::MODE_READ: begin
            w = '{1'b1, emb_re[{in_word, in_element}], emb_im[{in_word, in_element}]};
          end
          default: ctx_n = 0;
        endcase
        exp_words[exp_tail] = w;
        exp_tail = exp_tail + 4'd1;
        exp_count++;
      end
      if (out_valid && out_ready) begin
        if (exp_count == 0) begin
          report_mismatch("result words outstanding", 1, 0);
        end else begin
          want = exp_words[exp_head];
          exp_head = exp_head + 4'd1;
          exp_count--;
          if (out_read_valid !== want.rv)
            report_mismatch("read_valid", longint'(out_read_valid), longint'(want.rv));
          if (out_embed_real !== want.re)
            report_mismatch("embed_real", longint'(out_embed_real), longint'(want.re));
          if (out_embed_imag !== want.im)
            report_mismatch("embed_imag", longint'(out_embed_imag), longint'(want.im));
        end
      end
    end
  end

endmodule

/* tb/testbench.sv */
// Stimulus and verdict for the context bundler testbench
`timescale 1ns / 100ps
module testbench;

  localparam int CYCLE_LIMIT = 8000000;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 4;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  wire                in_ready;
  logic        [1:0]  in_mode = hvcb_pkg::MODE_CLEAR;
  logic        [7:0]  in_word = '0;
  logic        [7:0]  in_element = '0;
  logic signed [15:0] in_base_real = '0;
  logic signed [15:0] in_base_imag = '0;
  wire                out_valid;
  logic               out_ready = 1'b0;
  wire                out_read_valid;
  wire signed  [31:0] out_embed_real;
  wire signed  [31:0] out_embed_imag;
  logic               cfg_we = 1'b0;
  logic               cfg_index = hvcb_pkg::REG_DECAY;
  logic        [15:0] cfg_wdata = '0;
  int                 fails;
  int                 pending;

  int         cycles = 0;
  bit         calm = 1'b0;
  bit         win_empty = 1'b1;
  bit         dirty = 1'b0;   // window holds a word whose base vector is not fully loaded
  logic [7:0] full_word;
  int         n_tok = 0, n_load = 0, n_read = 0, n_clr = 0;
  logic [15:0] decay_set [NUM_PHASES] = '{16'd65535, 16'd0, 16'd32768, 16'd65470, 16'd1, 16'd40000};
  logic [2:0]  wlen_set  [NUM_PHASES] = '{3'd1, 3'd3, 3'd0, 3'd7, 3'd2, 3'd4};

  hypervector_context_bundler_top i_dut (.*);

  hvcb_scoreboard i_checker (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 18);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] mode, input logic [7:0] word,
                           input logic [7:0] elem, input logic signed [15:0] br,
                           input logic signed [15:0] bi);
    if (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_word <= word;
    in_element <= elem;
    in_base_real <= br;
    in_base_imag <= bi;
    do @(posedge clk); while (!in_ready);
    case (mode)
      hvcb_pkg::MODE_TOKEN: n_tok++;
      hvcb_pkg::MODE_LOAD:  n_load++;
      hvcb_pkg::MODE_READ:  n_read++;
      default:              n_clr++;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] base_val();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic token(input logic [7:0] w);
    send_word(hvcb_pkg::MODE_TOKEN, w, 8'($urandom), 16'($urandom), 16'($urandom));
    win_empty = 1'b0;
  endtask

  task automatic clear_window();
    send_word(hvcb_pkg::MODE_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
    win_empty = 1'b1;
  endtask

  task automatic random_word();
    logic [7:0] w;
    int r;
    r = $urandom_range(99);
    if (dirty) begin
      clear_window();
      dirty = 1'b0;
    end else if (r < 38) begin
      if (win_empty && $urandom_range(3) == 0) w = 8'($urandom);
      else w = full_word;
      dirty = (w != full_word);
      token(w);
    end else if (r < 60) begin
      w = $urandom_range(1) ? full_word : 8'($urandom);
      send_word(hvcb_pkg::MODE_LOAD, w, 8'($urandom), base_val(), base_val());
    end else if (r < 90) begin
      w = ($urandom_range(3) != 0) ? full_word : 8'($urandom);
      send_word(hvcb_pkg::MODE_READ, w, 8'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      clear_window();
    end
  endtask

  initial begin
    full_word = 8'($urandom);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    calm = 1'b1;

    // full base vector for the word that tokens may use with a non-empty window
    for (int e = 0; e < 256; e++)
      send_word(hvcb_pkg::MODE_LOAD, full_word, 8'(e), base_val(), base_val());
    send_word(hvcb_pkg::MODE_LOAD, full_word, 8'd0, 16'sh8000, 16'sh8000);
    send_word(hvcb_pkg::MODE_LOAD, full_word, 8'd255, 16'sh7fff, 16'sh7fff);
    calm = 1'b0;

    // directed: empty window, self context, full window, odd words and elements
    send_word(hvcb_pkg::MODE_READ, full_word, 8'd0, 16'sh7fff, 16'sh7fff);
    repeat (5) token(full_word);
    send_word(hvcb_pkg::MODE_READ, full_word, 8'd0, 16'sh0, 16'sh0);
    send_word(hvcb_pkg::MODE_READ, full_word, 8'd255, 16'sh8000, 16'sh8000);
    send_word(hvcb_pkg::MODE_LOAD, 8'd17, 8'd255, 16'sh1234, -16'sh1234);
    send_word(hvcb_pkg::MODE_READ, 8'd17, 8'd0, 16'sh0, 16'sh0);
    clear_window();
    token(8'd17);   // empty window: no base read
    clear_window();
    token(full_word);
    send_word(hvcb_pkg::MODE_READ, full_word, 8'd128, 16'sh0, 16'sh0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_reg(hvcb_pkg::REG_DECAY, decay_set[p]);
      write_reg(hvcb_pkg::REG_WLEN, {13'd0, wlen_set[p]});
      calm = (p == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) random_word();
    end
    calm = 1'b0;
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d tokens, %0d base loads, %0d reads, %0d window clears",
             n_tok, n_load, n_read, n_clr);
    $display("over %0d decay / window-length settings incl. 0, 65535 and lengths 0 and 7",
             NUM_PHASES);
    if (fails == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
